// ===== hdl/srrw_pkg.sv =====
// ---------------------------------------------------------------------------
// srrw_pkg
// Types and constants of the selective-repeat receive window.
// ---------------------------------------------------------------------------
package srrw_pkg;

	localparam int SEQ_W = 32;
	localparam int CFG_W = 6;
	localparam int MAP_W = 31;

	localparam logic [CFG_W-1:0] WIN_RESET = 6'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_SLIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [SEQ_W-1:0] a;
		logic [SEQ_W-1:0] b;
		logic             cin;
	} alu_op_t;

endpackage

// ===== hdl/srrw_addcmp.sv =====
// ---------------------------------------------------------------------------
// srrw_addcmp
// Shared adder with a limit compare on its sum: forms the window offset
// and advances the window base.
// ---------------------------------------------------------------------------
module srrw_addcmp (
	input  srrw_pkg::alu_op_t              op,
	input  logic [srrw_pkg::SEQ_W-1:0]     limit,
	output logic [srrw_pkg::SEQ_W-1:0]     sum,
	output logic                           lt
);
	import srrw_pkg::*;

	always_comb begin
		sum = op.a + op.b + SEQ_W'(op.cin);
		lt  = (sum < limit);
	end

endmodule

// ===== hdl/selective_repeat_receiver_window.sv =====
// Flow: a segment outside the window is acked with the window unchanged; a new
// segment slides the window by k slots (k up to MAX_WINDOW) before its ack;
// a duplicate gives no ack.
// Throughput: one segment in work at a time; the slide loop moves one slot per cycle
// through the shared adder. A waiting ack stalls the next segment at its emit step.
// Reset: window empty, base 0, last-seen clear, slot_count 8.
// ---------------------------------------------------------------------------
// selective_repeat_receiver_window
// Receiver side of a selective-repeat window: tracks received slots, slides
// the base past the leading run and returns a cumulative plus selective ack.
// ---------------------------------------------------------------------------
module selective_repeat_receiver_window #(
	parameter int MAX_WINDOW = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [srrw_pkg::CFG_W-1:0]    slot_count,

	input  logic                          seg_valid,
	output logic                          seg_ready,
	input  logic [srrw_pkg::SEQ_W-1:0]    seq_num,
	input  logic                          is_short,

	output logic                          ack_valid,
	input  logic                          ack_ready,
	output logic [srrw_pkg::SEQ_W-1:0]    ack_base,
	output logic [srrw_pkg::MAP_W-1:0]    sack_bits,
	output logic                          finished
);
	import srrw_pkg::*;

	localparam int IDX_W = $clog2(MAX_WINDOW);

	state_t                 state_q, state_d;
	logic [CFG_W-1:0]       wsize_q;
	logic [MAX_WINDOW-1:0]  rcv_q;
	logic [SEQ_W-1:0]       base_q;
	logic                   last_q;
	logic [SEQ_W-1:0]       seq_q;
	logic                   short_q;

	logic                   ack_valid_q;
	logic [SEQ_W-1:0]       ack_base_q;
	logic [MAP_W-1:0]       ack_map_q;
	logic                   ack_fin_q;

	logic [CFG_W-1:0]       eff;
	logic [CFG_W-1:0]       new_eff;
	logic [MAX_WINDOW-1:0]  keep;
	alu_op_t                op;
	logic [SEQ_W-1:0]       sum;
	logic                   in_win;
	logic                   hit;
	logic                   emit_go;

	function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] ws);
		logic [CFG_W-1:0] s;
		s = ws;
		if (s == '0)
			s = CFG_W'(1);
		if (s > CFG_W'(MAX_WINDOW))
			s = CFG_W'(MAX_WINDOW);
		return s;
	endfunction

	assign eff     = clamp_size(wsize_q);
	assign new_eff = clamp_size(slot_count);

	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++)
			keep[i] = (CFG_W'(i) < new_eff);
	end

	srrw_addcmp u_addcmp (
		.op    (op),
		.limit (SEQ_W'(eff)),
		.sum   (sum),
		.lt    (in_win)
	);

	assign hit     = rcv_q[sum[IDX_W-1:0]];
	assign emit_go = !ack_valid_q || ack_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (seg_valid) state_d = ST_CALC;
			ST_CALC: begin
				if (!in_win)
					state_d = ST_EMIT;
				else if (hit)
					state_d = ST_IDLE;
				else
					state_d = ST_SLIDE;
			end
			ST_SLIDE: if (!rcv_q[0]) state_d = ST_EMIT;
			ST_EMIT:  if (emit_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs and shared unit operands
	always_comb begin
		seg_ready = 1'b0;
		cfg_ready = 1'b0;
		op.a      = base_q;
		op.b      = '0;
		op.cin    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				seg_ready = 1'b1;
				cfg_ready = 1'b1;
			end
			ST_CALC: begin
				op.a = seq_q;
				op.b = ~base_q;
			end
			ST_SLIDE: ;
			ST_EMIT:  ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wsize_q     <= WIN_RESET;
			rcv_q       <= '0;
			base_q      <= '0;
			last_q      <= 1'b0;
			ack_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				wsize_q <= slot_count;
				rcv_q   <= rcv_q & keep;
			end
			case (state_q)
				ST_CALC: begin
					if (in_win) begin
						if (short_q)
							last_q <= 1'b1;
						rcv_q[sum[IDX_W-1:0]] <= 1'b1;
					end
				end
				ST_SLIDE: begin
					if (rcv_q[0]) begin
						rcv_q  <= rcv_q >> 1;
						base_q <= sum;
					end
				end
				default: ;
			endcase
			if (state_q == ST_EMIT && emit_go)
				ack_valid_q <= 1'b1;
			else if (ack_ready)
				ack_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seg_valid && seg_ready) begin
			seq_q   <= seq_num;
			short_q <= is_short;
		end
		if (state_q == ST_EMIT && emit_go) begin
			ack_base_q <= base_q;
			ack_map_q  <= MAP_W'(rcv_q[MAX_WINDOW-1:1]);
			ack_fin_q  <= last_q && (rcv_q == '0);
		end
	end

	assign ack_valid = ack_valid_q;
	assign ack_base  = ack_base_q;
	assign sack_bits = ack_map_q;
	assign finished  = ack_fin_q;

endmodule

// ===== hdl/srrw_checker.sv =====
// ---------------------------------------------------------------------------
// srrw_checker
// Port-level checks of the selective-repeat receive window, bound to the
// top level.
// ---------------------------------------------------------------------------
module srrw_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic                          seg_valid,
	input logic                          seg_ready,
	input logic                          ack_valid,
	input logic                          ack_ready,
	input logic [srrw_pkg::SEQ_W-1:0]    ack_base,
	input logic [srrw_pkg::MAP_W-1:0]    sack_bits,
	input logic                          finished
);
	import srrw_pkg::*;

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_ready |=> !seg_ready)
		else $error("segment taken while previous one in work");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == seg_ready)
		else $error("config ready outside idle");

	a_fin_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ack_valid && finished |-> sack_bits == '0)
		else $error("finished with slots still marked");

	a_ack_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ack_valid && !ack_ready |=> ack_valid && $stable(ack_base)
			&& $stable(sack_bits) && $stable(finished))
		else $error("stalled ack beat changed");

endmodule

bind selective_repeat_receiver_window srrw_checker u_srrw_checker (.*);

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Testbench of the selective-repeat receive window. A model of the window
// inside the bench predicts each ack from the accepted segments; a checker
// compares every ack beat with the oldest prediction. Directed tests cover
// the window edges, duplicates, the final-segment flag and size rewrites;
// random tests run many window sizes under random idling and one long ack
// stall.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import srrw_pkg::*;

	localparam int MAX_WIN    = 32;
	localparam int DRAIN_WAIT = 60;
	localparam int STALL_LEN  = 400;
	localparam int WD_LIMIT   = 5000;

	typedef struct packed {
		logic [SEQ_W-1:0] base;
		logic [MAP_W-1:0] sel;
		logic             fin;
	} ack_t;

	logic             clk;
	logic             arst_n         = 1'b0;
	logic             cfg_valid      = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] slot_count     = '0;
	logic             seg_valid      = 1'b0;
	logic             seg_ready;
	logic [SEQ_W-1:0] seq_num        = '0;
	logic             is_short       = 1'b0;
	logic             ack_valid;
	logic             ack_ready      = 1'b0;
	logic [SEQ_W-1:0] ack_base;
	logic [MAP_W-1:0] sack_bits;
	logic             finished;

	// window model
	logic [CFG_W-1:0] win_reg  = WIN_RESET;
	logic [31:0]      rcv_bits = '0;
	logic [SEQ_W-1:0] base_q   = '0;
	logic             last_q   = 1'b0;

	ack_t pending_acks[$];
	int   errors    = 0;
	bit   seg_calm  = 1'b0;
	bit   ack_calm  = 1'b0;
	bit   stall_req = 1'b0;

	selective_repeat_receiver_window #(
		.MAX_WINDOW(MAX_WIN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.slot_count(slot_count),
		.seg_valid(seg_valid),
		.seg_ready(seg_ready),
		.seq_num(seq_num),
		.is_short(is_short),
		.ack_valid(ack_valid),
		.ack_ready(ack_ready),
		.ack_base(ack_base),
		.sack_bits(sack_bits),
		.finished(finished)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_window();
		int s;
		s = int'(win_reg);
		if (s < 1) s = 1;
		if (s > MAX_WIN) s = MAX_WIN;
		return s;
	endfunction

	function automatic logic [31:0] slot_mask(int s);
		logic [63:0] m;
		m = (64'd1 << s) - 64'd1;
		return m[31:0];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// advance the window for one accepted segment; returns 1 if an ack follows
	function automatic bit slide_window(logic [SEQ_W-1:0] seq, logic sh, output ack_t a);
		int          size;
		logic [31:0] off;
		logic [31:0] sel;
		size = eff_window();
		off  = seq - base_q;
		a    = '0;
		if (off < size) begin
			if (sh) last_q = 1'b1;
			if (rcv_bits[off[4:0]]) return 1'b0;
			rcv_bits[off[4:0]] = 1'b1;
			while (rcv_bits[0]) begin
				rcv_bits = rcv_bits >> 1;
				base_q   = base_q + 1;
			end
		end
		sel    = (rcv_bits >> 1) & slot_mask(size - 1);
		a.base = base_q;
		a.sel  = sel[MAP_W-1:0];
		a.fin  = last_q && (rcv_bits == '0);
		return 1'b1;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	// one segment beat; starts and ends at a falling edge
	task automatic send_seg(logic [SEQ_W-1:0] seq, logic sh);
		int   gap;
		ack_t a;
		gap = seg_calm ? 0 : pick_gap();
		if (gap > 0) begin
			seg_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		seg_valid <= 1'b1;
		seq_num   <= seq;
		is_short  <= sh;
		do @(posedge clk); while (!seg_ready);
		if (slide_window(seq, sh, a)) pending_acks.push_back(a);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		seg_valid <= 1'b0;
		while (pending_acks.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_W-1:0] val);
		wait_idle();
		cfg_valid  <= 1'b1;
		slot_count <= val;
		do @(posedge clk); while (!cfg_ready);
		win_reg  = val;
		rcv_bits = rcv_bits & slot_mask(eff_window());
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [SEQ_W-1:0] pick_seq();
		int r;
		int size;
		size = eff_window();
		r    = $urandom_range(0, 99);
		if (r < 75) return base_q + $urandom_range(0, size - 1);
		if (r < 85) return base_q + size + $urandom_range(0, 3);
		if (r < 90) return base_q - $urandom_range(1, 4);
		return $urandom;
	endfunction

	task automatic test_reset_window();
		send_seg(32'd0, 1'b0);
		send_seg(32'd0, 1'b0);
		send_seg(32'd2, 1'b0);
		send_seg(32'd2, 1'b0);
		send_seg(32'd2, 1'b1);
		send_seg(32'd1, 1'b0);
		send_seg(32'd10, 1'b0);
		send_seg(32'd11, 1'b0);
		send_seg(32'hFFFF_FFFF, 1'b1);
		send_seg(32'h8000_0000, 1'b1);
		send_seg(32'h5555_5555, 1'b0);
		send_seg(32'hAAAA_AAAA, 1'b1);
		send_seg(32'd3, 1'b0);
		for (int s = 4; s <= 9; s++) send_seg(32'(s), 1'b0);
		send_seg(32'd11, 1'b0);
		send_seg(32'd13, 1'b0);
	endtask

	task automatic test_window_size();
		cfg_write(6'd0);
		send_seg(base_q, 1'b0);
		send_seg(base_q + 1, 1'b0);
		send_seg(base_q, 1'b1);
		cfg_write(6'd63);
		send_seg(base_q + 31, 1'b0);
		send_seg(base_q + 32, 1'b0);
		send_seg(base_q + 31, 1'b0);
		cfg_write(6'd33);
		cfg_write(6'd32);
		send_seg(base_q + 20, 1'b0);
		send_seg(base_q + 2, 1'b0);
		cfg_write(6'd4);
		send_seg(base_q + 20, 1'b0);
		send_seg(base_q + 1, 1'b0);
		send_seg(base_q, 1'b0);
	endtask

	task automatic test_random_traffic();
		logic [CFG_W-1:0] sizes[8];
		sizes = '{6'd1, 6'd2, 6'd8, 6'd32, 6'd63, 6'd0, 6'd17, 6'd8};
		foreach (sizes[i]) begin
			if (i == 7) sizes[i] = CFG_W'($urandom_range(0, 63));
			cfg_write(sizes[i]);
			seg_calm = ($urandom_range(0, 3) == 0);
			ack_calm = ($urandom_range(0, 3) == 0);
			repeat (190) send_seg(pick_seq(), ($urandom_range(0, 99) < 8));
		end
		seg_calm = 1'b0;
		ack_calm = 1'b0;
	endtask

	task automatic test_backpressure();
		cfg_write(6'd32);
		seg_calm  = 1'b1;
		stall_req = 1'b1;
		repeat (110) send_seg(pick_seq(), ($urandom_range(0, 99) < 5));
		seg_calm = 1'b0;
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_window();
		test_window_size();
		test_random_traffic();
		test_backpressure();
		wait_idle();
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// ack receiver: random gaps, quiet stretches, one long stall on request
	initial begin
		int stall_left;
		int gap_left;
		stall_left = 0;
		gap_left   = 0;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				stall_left = STALL_LEN;
				stall_req  = 1'b0;
			end
			if (stall_left > 0) begin
				ack_ready <= 1'b0;
				stall_left--;
			end else if (ack_calm) begin
				ack_ready <= 1'b1;
			end else if (gap_left > 0) begin
				ack_ready <= 1'b0;
				gap_left--;
			end else begin
				ack_ready <= 1'b1;
				gap_left = pick_gap();
			end
		end
	end

	// ack checker
	always @(posedge clk) begin
		ack_t want;
		if (arst_n && ack_valid && ack_ready) begin
			if (pending_acks.size() == 0) begin
				report("unexpected ack base", ack_base, 32'd0);
			end else begin
				want = pending_acks.pop_front();
				if (ack_base !== want.base) report("ack_base", ack_base, want.base);
				if (sack_bits !== want.sel)
					report("sack_bits", {1'b0, sack_bits}, {1'b0, want.sel});
				if (finished !== want.fin)
					report("finished", 32'(finished), 32'(want.fin));
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((seg_valid && seg_ready) || (ack_valid && ack_ready) ||
			    (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WD_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

endmodule
